// File: rtl/olist_pkg.sv
// shared types, widths and codes for the ordered list engine
`timescale 1ns / 1ps

package olist_pkg;

  // list depth and the width of a count that can hold it
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int PLACE_W  = 8;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 7;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DELETE    = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_BADPOS   = 3'd1,
    STS_NOTFOUND = 3'd2,
    STS_FULL     = 3'd3,
    STS_EMPTY    = 3'd4
  } status_t;

  // what the cell row does on each clock edge
  typedef enum logic [1:0] {
    E_HOLD,
    E_INSERT,
    E_DELETE,
    E_ROTATE
  } edit_op_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } olist_state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    edit_op_t op;
    logic     at_pos;    // this cell is the insert point
    logic     past_pos;  // this cell lies right of the insert point
    logic     occupied;  // this cell holds a live entry
    logic     is_tail;   // this cell holds the last live entry
  } cell_ctl_t;

endpackage

// File: rtl/ordered_list_engine.sv
// top level of the ordered list engine: sequencer, cell row and result register
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   input   | in_valid in_stall in_command in_value in_place | in
//   result  | out_valid out_stall out_status out_entry       | out
//           | out_index out_occupancy out_last              |
//
// An edit item's single result is registered at the edge that accepts it;
// the next item is taken as soon as the result register is free.
// A readout of n entries rotates the cell row once per cycle while the result side is free
// and gives n results (at least one); no item is accepted until the last one is shown.
// Reset empties the list at once; entry cells keep whatever they held.
// A stall on the result side holds the result and the rotation in place.
`timescale 1ns / 1ps

module ordered_list_engine (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [olist_pkg::CMD_W-1:0]    in_command,
  input  logic signed [olist_pkg::DATA_W-1:0]   in_value,
  input  logic        [olist_pkg::PLACE_W-1:0]  in_place,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [olist_pkg::STATUS_W-1:0] out_status,
  output logic signed [olist_pkg::DATA_W-1:0]   out_entry,
  output logic        [olist_pkg::INDEX_W-1:0]  out_index,
  output logic        [olist_pkg::INDEX_W-1:0]  out_occupancy,
  output logic                                  out_last
);

  localparam int CAP = olist_pkg::CAPACITY;
  localparam int CW  = olist_pkg::CNT_W;
  localparam int DW  = olist_pkg::DATA_W;

  olist_pkg::olist_state_t state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           rd_cnt_r, rd_cnt_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  logic [olist_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [DW-1:0]                        out_entry_r, out_entry_nxt;
  logic [olist_pkg::INDEX_W-1:0]        out_index_r, out_index_nxt;
  logic [olist_pkg::INDEX_W-1:0]        out_occ_r, out_occ_nxt;
  logic                                 out_last_r, out_last_nxt;

  logic                     in_fire;
  logic                     out_free;
  olist_pkg::edit_op_t      edit_op;
  logic [CW-1:0]            ins_pos;
  logic [olist_pkg::PLACE_W-1:0] place_m1;
  logic [CW-1:0]            rd_cnt_inc;

  olist_pkg::cell_ctl_t     ctl       [CAP];
  logic [DW-1:0]            cell_data [CAP];
  logic [DW-1:0]            left_data [CAP];
  logic [DW-1:0]            right_data[CAP];
  logic                     hit       [CAP+1];

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != olist_pkg::ST_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;

  // insert point, clipped to the end of the list
  assign place_m1 = in_place - olist_pkg::PLACE_W'(1);
  always_comb begin
    case (in_command)
      olist_pkg::CMD_INS_FRONT: ins_pos = '0;
      olist_pkg::CMD_INS_END:   ins_pos = count_r;
      default: begin
        if (place_m1 > olist_pkg::PLACE_W'(count_r)) begin
          ins_pos = count_r;
        end else begin
          ins_pos = place_m1[CW-1:0];
        end
      end
    endcase
  end

  assign rd_cnt_inc = rd_cnt_r + CW'(1);

  // sequencer: next state, cell row command and result register
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_cnt_nxt     = rd_cnt_r;
    edit_op        = olist_pkg::E_HOLD;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_index_nxt  = out_index_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      olist_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = olist_pkg::STS_OK;
          out_entry_nxt  = in_value;
          out_index_nxt  = '0;
          out_last_nxt   = 1'b1;
          case (in_command)
            olist_pkg::CMD_INS_FRONT, olist_pkg::CMD_INS_END, olist_pkg::CMD_INS_POS: begin
              if ((in_command == olist_pkg::CMD_INS_POS) && (in_place == '0)) begin
                out_status_nxt = olist_pkg::STS_BADPOS;
              end else if (count_r == CW'(CAP)) begin
                out_status_nxt = olist_pkg::STS_FULL;
              end else begin
                edit_op   = olist_pkg::E_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            olist_pkg::CMD_DELETE: begin
              edit_op = olist_pkg::E_DELETE;
              if (hit[CAP]) begin
                count_nxt = count_r - CW'(1);
              end else begin
                out_status_nxt = olist_pkg::STS_NOTFOUND;
              end
            end
            olist_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            olist_pkg::CMD_READ: begin
              if (count_r == '0) begin
                out_status_nxt = olist_pkg::STS_EMPTY;
              end else begin
                // first entry sits in the head cell; rotate it to the tail
                edit_op       = olist_pkg::E_ROTATE;
                out_entry_nxt = cell_data[0];
                out_index_nxt = olist_pkg::INDEX_W'(1);
                out_last_nxt  = (count_r == CW'(1));
                rd_cnt_nxt    = CW'(1);
                if (count_r != CW'(1)) begin
                  state_nxt = olist_pkg::ST_READ;
                end
              end
            end
            default: begin
              out_status_nxt = olist_pkg::STS_OK;
            end
          endcase
          out_occ_nxt = olist_pkg::INDEX_W'(count_nxt);
        end
      end
      olist_pkg::ST_READ: begin
        if (out_free) begin
          edit_op        = olist_pkg::E_ROTATE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = olist_pkg::STS_OK;
          out_entry_nxt  = cell_data[0];
          out_index_nxt  = olist_pkg::INDEX_W'(rd_cnt_inc);
          out_occ_nxt    = olist_pkg::INDEX_W'(count_r);
          out_last_nxt   = (rd_cnt_inc == count_r);
          rd_cnt_nxt     = rd_cnt_inc;
          if (rd_cnt_inc == count_r) begin
            state_nxt = olist_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = olist_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olist_pkg::ST_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_index_r  <= out_index_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_entry     = out_entry_r;
  assign out_index     = out_index_r;
  assign out_occupancy = out_occ_r;
  assign out_last      = out_last_r;

  // cell row
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    // neighbor links, open at both ends
    if (i == 0) begin : g_first
      assign left_data[i] = '0;
    end else begin : g_inner_l
      assign left_data[i] = cell_data[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign right_data[i] = '0;
    end else begin : g_inner_r
      assign right_data[i] = cell_data[i+1];
    end

    // per-cell flags from the insert point and the fill count
    assign ctl[i].op       = edit_op;
    assign ctl[i].at_pos   = (ins_pos == CW'(i));
    assign ctl[i].past_pos = (ins_pos < CW'(i));
    assign ctl[i].occupied = (CW'(i) < count_r);
    assign ctl[i].is_tail  = (CW'(i + 1) == count_r);

    olist_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .new_value  (in_value),
      .left_data  (left_data[i]),
      .right_data (right_data[i]),
      .head_data  (cell_data[0]),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .data       (cell_data[i])
    );
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("fill count above capacity");

  a_read_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olist_pkg::ST_READ) |-> (out_valid_r && !out_last_r))
    else $error("readout in progress without a pending non-final result");

  a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olist_pkg::ST_READ) |=> $stable(count_r))
    else $error("fill count changed during readout");

  a_read_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olist_pkg::ST_READ) |-> (rd_cnt_r < count_r))
    else $error("readout counter ran past the list");

endmodule

// File: rtl/olist_cell.sv
// one storage cell of the list row: holds one entry and trades with its neighbors
`timescale 1ns / 1ps

module olist_cell (
  input  logic                           clk,
  input  olist_pkg::cell_ctl_t           ctl,
  input  logic [olist_pkg::DATA_W-1:0]   new_value,
  input  logic [olist_pkg::DATA_W-1:0]   left_data,
  input  logic [olist_pkg::DATA_W-1:0]   right_data,
  input  logic [olist_pkg::DATA_W-1:0]   head_data,
  input  logic                           hit_in,
  output logic                           hit_out,
  output logic [olist_pkg::DATA_W-1:0]   data
);

  logic [olist_pkg::DATA_W-1:0] data_r;
  logic [olist_pkg::DATA_W-1:0] data_nxt;
  logic                         hit_here;

  // key match chain: a hit here or to the left closes the gap
  assign hit_here = ctl.occupied && (data_r == new_value);
  assign hit_out  = hit_in || hit_here;

  // next entry value
  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      olist_pkg::E_INSERT: begin
        if (ctl.at_pos) begin
          data_nxt = new_value;
        end else if (ctl.past_pos) begin
          data_nxt = left_data;
        end
      end
      olist_pkg::E_DELETE: begin
        if (hit_out) begin
          data_nxt = right_data;
        end
      end
      olist_pkg::E_ROTATE: begin
        data_nxt = ctl.is_tail ? head_data : right_data;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // entry register
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
